FILE: rtl/core/clle_pkg.sv
// ----------------------------------------------------------------------------
// clle_pkg
// Shared types and constants of the circular linked list engine: id width,
// action codes and the sequencer states.
// ----------------------------------------------------------------------------
package clle_pkg;

    // width of a node id as it travels on the ports and in the link tables
    localparam int ID_W  = 10;
    localparam int ACT_W = 3;

    // action codes carried by an input item
    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND     = 3'd0,
        ACT_INS_AFTER  = 3'd1,
        ACT_INS_BEFORE = 3'd2,
        ACT_REM_NEXT   = 3'd3,
        ACT_REM_PREV   = 3'd4
    } action_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_CLOSE,
        ST_LINK,
        ST_SPLICE,
        ST_SPLICE2,
        ST_FAR
    } state_t;

endpackage

FILE: rtl/core/clle_ram.sv
// ----------------------------------------------------------------------------
// clle_ram
// Generic simple dual port RAM: one write port, one read port, read data
// registered (holds while no read is issued).
// ----------------------------------------------------------------------------
module clle_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // storage write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/clle_slot.sv
// ----------------------------------------------------------------------------
// clle_slot
// Maps a node id onto a table entry: the id reduced modulo the table depth.
// Narrow tables use a folded constant lookup instead of a divider.
// ----------------------------------------------------------------------------
module clle_slot #(
    parameter int NODE_COUNT = 1024,
    localparam int AW        = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1
) (
    input  logic [clle_pkg::ID_W-1:0] id,
    output logic [AW-1:0]             slot
);

    generate
        if (NODE_COUNT >= 1024)
        begin : g_direct
            // every id fits the table as it is
            assign slot = AW'(id);
        end
        else
        begin : g_fold
            logic [AW-1:0] hi_tab [32];
            logic [AW+5:0] part;

            // upper five id bits times 32, already reduced
            for (genvar g = 0; g < 32; g++)
            begin : g_hi
                assign hi_tab[g] = AW'((g * 32) % NODE_COUNT);
            end

            // partial sum stays below NODE_COUNT + 31
            assign part = (AW+6)'(hi_tab[id[9:5]]) + (AW+6)'(id[4:0]);

            if (NODE_COUNT >= 32)
            begin : g_sub
                // one conditional subtract finishes the reduction
                assign slot = (part >= (AW+6)'(NODE_COUNT))
                            ? AW'(part - (AW+6)'(NODE_COUNT))
                            : AW'(part);
            end
            else
            begin : g_lut
                logic [AW-1:0] lo_tab [64];

                // tiny tables: finish with a 64 entry lookup
                for (genvar g = 0; g < 64; g++)
                begin : g_lo
                    assign lo_tab[g] = AW'(g % NODE_COUNT);
                end
                assign slot = lo_tab[part[5:0]];
            end
        end
    endgenerate

endmodule

FILE: rtl/core/circular_linked_list_engine.sv
// ----------------------------------------------------------------------------
// circular_linked_list_engine
// Circular doubly linked list of node ids kept in two link RAMs (prev, next)
// indexed by id; append builds a ring, inserts splice and removals unlink.
// ----------------------------------------------------------------------------
// Usage
//   Command channel: cmd_valid / cmd_stall with action, station, new_station
//   and ring_end. An item is taken when cmd_valid is high and cmd_stall low.
//   Result channel: res_valid / res_stall with result_station; inserts and
//   removals give one result, append and unknown actions give none.
//   One item is worked on at a time: an append passes ST_APPEND (and ST_CLOSE
//   when it closes the ring), an insert ST_LINK, ST_SPLICE and ST_SPLICE2, a
//   removal ST_LINK and ST_FAR; an unknown action is dropped on accept. This
//   follows from the registered reads of the link RAMs (the removal reads the
//   neighbour of the neighbour) and from their single write port (an insert
//   writes each table twice). A result is registered on res_* from ST_SPLICE2
//   (insert) or ST_FAR (removal). While res_stall holds a result, the next item
//   is still accepted and worked on; it waits only at its final write.
//   Reset clears the ring builder (head, last appended, open flag) and the
//   result valid; link RAM contents are undefined until written and get no
//   clearing pass.
// ----------------------------------------------------------------------------
module circular_linked_list_engine #(
    parameter int NODE_COUNT = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_stall,
    input  logic [2:0]                action,
    input  logic [9:0]                station,
    input  logic [9:0]                new_station,
    input  logic                      ring_end,
    output logic                      res_valid,
    input  logic                      res_stall,
    output logic [9:0]                result_station
);

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int IW = clle_pkg::ID_W;

    clle_pkg::state_t  state_reg, state_next;
    clle_pkg::action_t action_reg, action_next;
    logic [IW-1:0]     a_reg, a_next;
    logic [IW-1:0]     b_reg, b_next;
    logic              end_reg, end_next;
    logic [IW-1:0]     t_reg, t_next;
    logic [IW-1:0]     head_reg, head_next;
    logic [IW-1:0]     last_reg, last_next;
    logic              open_reg, open_next;
    logic              res_valid_reg, res_valid_next;
    logic [IW-1:0]     res_station_reg, res_station_next;

    logic              cmd_fire;
    logic              out_free;
    logic              next_side;
    logic              res_load;
    logic [IW-1:0]     t_rd;
    logic [IW-1:0]     u_rd;
    logic [IW-1:0]     t_sel;

    logic [AW-1:0]     in_slot, a_slot, b_slot, t_slot, u_slot, head_slot, last_slot;

    logic              prev_we, next_we, rd_en;
    logic [AW-1:0]     prev_waddr, next_waddr, rd_addr;
    logic [IW-1:0]     prev_wdata, next_wdata;
    logic [IW-1:0]     prev_rdata, next_rdata;

    // handshake
    assign cmd_stall      = (state_reg != clle_pkg::ST_IDLE);
    assign cmd_fire       = cmd_valid && !cmd_stall;
    assign out_free       = !res_valid_reg || !res_stall;
    assign res_valid      = res_valid_reg;
    assign result_station = res_station_reg;

    // which table the operation walks along
    assign next_side = (action_reg == clle_pkg::ACT_INS_AFTER)
                    || (action_reg == clle_pkg::ACT_REM_NEXT);
    assign t_rd      = next_side ? next_rdata : prev_rdata;
    assign u_rd      = next_side ? next_rdata : prev_rdata;
    assign t_sel     = (state_reg == clle_pkg::ST_LINK) ? t_rd : t_reg;

    // id to table entry mapping
    clle_slot #(.NODE_COUNT(NODE_COUNT)) u_slot_in   (.id(station),  .slot(in_slot));
    clle_slot #(.NODE_COUNT(NODE_COUNT)) u_slot_a    (.id(a_reg),    .slot(a_slot));
    clle_slot #(.NODE_COUNT(NODE_COUNT)) u_slot_b    (.id(b_reg),    .slot(b_slot));
    clle_slot #(.NODE_COUNT(NODE_COUNT)) u_slot_t    (.id(t_sel),    .slot(t_slot));
    clle_slot #(.NODE_COUNT(NODE_COUNT)) u_slot_u    (.id(u_rd),     .slot(u_slot));
    clle_slot #(.NODE_COUNT(NODE_COUNT)) u_slot_head (.id(head_reg), .slot(head_slot));
    clle_slot #(.NODE_COUNT(NODE_COUNT)) u_slot_last (.id(last_reg), .slot(last_slot));

    // link tables, both read at the same address
    clle_ram #(.WIDTH(IW), .DEPTH(NODE_COUNT)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (prev_rdata)
    );

    clle_ram #(.WIDTH(IW), .DEPTH(NODE_COUNT)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (next_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            clle_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (clle_pkg::action_t'(action))
                        clle_pkg::ACT_APPEND:     state_next = clle_pkg::ST_APPEND;
                        clle_pkg::ACT_INS_AFTER,
                        clle_pkg::ACT_INS_BEFORE,
                        clle_pkg::ACT_REM_NEXT,
                        clle_pkg::ACT_REM_PREV:   state_next = clle_pkg::ST_LINK;
                        default:                  state_next = clle_pkg::ST_IDLE;
                    endcase
                end
            end
            clle_pkg::ST_APPEND:
            begin
                state_next = (open_reg && end_reg) ? clle_pkg::ST_CLOSE
                                                   : clle_pkg::ST_IDLE;
            end
            clle_pkg::ST_CLOSE:
            begin
                state_next = clle_pkg::ST_IDLE;
            end
            clle_pkg::ST_LINK:
            begin
                if ((action_reg == clle_pkg::ACT_INS_AFTER)
                    || (action_reg == clle_pkg::ACT_INS_BEFORE))
                begin
                    state_next = clle_pkg::ST_SPLICE;
                end
                else
                begin
                    state_next = clle_pkg::ST_FAR;
                end
            end
            clle_pkg::ST_SPLICE:
            begin
                state_next = clle_pkg::ST_SPLICE2;
            end
            clle_pkg::ST_SPLICE2,
            clle_pkg::ST_FAR:
            begin
                if (out_free)
                begin
                    state_next = clle_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = clle_pkg::ST_IDLE;
            end
        endcase
    end

    // memory control and register updates
    always_comb
    begin
        rd_en            = 1'b0;
        rd_addr          = in_slot;
        prev_we          = 1'b0;
        prev_waddr       = a_slot;
        prev_wdata       = a_reg;
        next_we          = 1'b0;
        next_waddr       = a_slot;
        next_wdata       = a_reg;
        res_load         = 1'b0;
        action_next      = action_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        end_next         = end_reg;
        t_next           = t_reg;
        head_next        = head_reg;
        last_next        = last_reg;
        open_next        = open_reg;
        case (state_reg)
            clle_pkg::ST_IDLE:
            begin
                // read both neighbours of the reference node on accept
                rd_en   = cmd_fire;
                rd_addr = in_slot;
                if (cmd_fire)
                begin
                    action_next = clle_pkg::action_t'(action);
                    a_next      = station;
                    b_next      = new_station;
                    end_next    = ring_end;
                end
            end
            clle_pkg::ST_APPEND:
            begin
                if (!open_reg)
                begin
                    // start a ring; a lone station links to itself
                    head_next = a_reg;
                    last_next = a_reg;
                    open_next = !end_reg;
                    prev_we    = end_reg;
                    prev_waddr = a_slot;
                    prev_wdata = a_reg;
                    next_we    = end_reg;
                    next_waddr = a_slot;
                    next_wdata = a_reg;
                end
                else
                begin
                    // chain after the last appended station
                    last_next  = a_reg;
                    prev_we    = 1'b1;
                    prev_waddr = a_slot;
                    prev_wdata = last_reg;
                    next_we    = 1'b1;
                    next_waddr = last_slot;
                    next_wdata = a_reg;
                end
            end
            clle_pkg::ST_CLOSE:
            begin
                // close the ring back to its head
                open_next  = 1'b0;
                next_we    = 1'b1;
                next_waddr = a_slot;
                next_wdata = head_reg;
                prev_we    = 1'b1;
                prev_waddr = head_slot;
                prev_wdata = a_reg;
            end
            clle_pkg::ST_LINK:
            begin
                // neighbour is known; fetch its own neighbour for removals
                t_next  = t_rd;
                rd_en   = 1'b1;
                rd_addr = t_slot;
            end
            clle_pkg::ST_SPLICE:
            begin
                // links of the new node
                prev_we    = 1'b1;
                prev_waddr = b_slot;
                prev_wdata = next_side ? a_reg : t_reg;
                next_we    = 1'b1;
                next_waddr = b_slot;
                next_wdata = next_side ? t_reg : a_reg;
            end
            clle_pkg::ST_SPLICE2:
            begin
                // point both old neighbours at the new node
                prev_we    = out_free;
                prev_waddr = next_side ? t_slot : a_slot;
                prev_wdata = b_reg;
                next_we    = out_free;
                next_waddr = next_side ? a_slot : t_slot;
                next_wdata = b_reg;
                res_load   = out_free;
            end
            clle_pkg::ST_FAR:
            begin
                // bridge over the removed node
                prev_we    = out_free;
                prev_waddr = next_side ? u_slot : a_slot;
                prev_wdata = next_side ? a_reg : u_rd;
                next_we    = out_free;
                next_waddr = next_side ? a_slot : u_slot;
                next_wdata = next_side ? u_rd : a_reg;
                res_load   = out_free;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // result register
    always_comb
    begin
        res_valid_next   = res_load || (res_valid_reg && res_stall);
        res_station_next = res_load ? t_reg : res_station_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= clle_pkg::ST_IDLE;
            head_reg      <= '0;
            last_reg      <= '0;
            open_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            last_reg      <= last_next;
            open_reg      <= open_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        action_reg      <= action_next;
        a_reg           <= a_next;
        b_reg           <= b_next;
        end_reg         <= end_next;
        t_reg           <= t_next;
        res_station_reg <= res_station_next;
    end

endmodule
